// ===== rtl/rkh_pkg.sv =====
// rolling key hash: shared constants, types and the residue fold table
// used by the residue update, the mixer and the top level; no dependencies
`default_nettype none

package rkh_pkg;

  localparam int HashWidth  = 30;
  localparam int ByteWidth  = 8;
  localparam int IdxWidth   = 5;
  localparam int ProdWidth  = 38;  // residue * 263 + byte term stays below 2^38
  localparam int SumWidth   = 31;

  localparam logic [HashWidth-1:0] HashMod  = 30'd1000000009;
  localparam logic [8:0]           HashBase = 9'd263;
  localparam logic [SumWidth-1:0]  HashMod2 = 31'd2000000018;
  localparam logic [IdxWidth-1:0]  IdxFull  = 5'd30;
  localparam logic [IdxWidth-1:0]  IdxReset = 5'd4;

  localparam int MixShiftA = 20;
  localparam int MixShiftB = 12;
  localparam int MixShiftC = 7;
  localparam int MixShiftD = 4;

  typedef logic [HashWidth-1:0] hash_t;
  typedef logic [ByteWidth-1:0] key_byte_t;
  typedef logic [IdxWidth-1:0]  idx_bits_t;

  // entry i holds (i * 2^30) mod p, folds the top byte of the product back in
  typedef logic [HashWidth-1:0] fold_table_t [256];

  function automatic fold_table_t build_fold_table();
    fold_table_t tbl;
    logic [63:0] v;
    for (int i = 0; i < 256; i++) begin
      v = (64'(i) << HashWidth) % 64'(HashMod);
      tbl[i] = v[HashWidth-1:0];
    end
    return tbl;
  endfunction

  localparam fold_table_t FoldTable = build_fold_table();

endpackage

`default_nettype wire

// ===== rtl/rkh_in_if.sv =====
// rolling key hash: key byte channel, one byte per transfer
// depends on rkh_pkg
`default_nettype none

interface rkh_in_if;
  logic               valid;
  logic               ready;
  rkh_pkg::key_byte_t key_byte;
  logic               byte_valid;
  logic               last;

  modport source (output valid, key_byte, byte_valid, last, input ready);
  modport sink   (input valid, key_byte, byte_valid, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rkh_out_if.sv =====
// rolling key hash: result channel, one hash and bucket index per transfer
// depends on rkh_pkg
`default_nettype none

interface rkh_out_if;
  logic           valid;
  logic           ready;
  rkh_pkg::hash_t key_hash;
  rkh_pkg::hash_t bucket_index;

  modport source (output valid, key_hash, bucket_index, input ready);
  modport sink   (input valid, key_hash, bucket_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/rolling_key_hash.sv =====
// rolling key hash: top level with input register, residue and result register
// depends on rkh_pkg, rkh_in_if, rkh_out_if, rkh_fold, rkh_mix
//
// Usage:
//   key_in carries the bytes of a key, first to last, one per transfer. A byte
//   with byte_valid low is skipped; last marks the final item of a key, which
//   may be an empty key (byte_valid low, last high).
//   hash_out gives one transfer per key: the mixed hash and the bucket index,
//   the hash masked to its low index_bits bits (all 30 bits at 30 or more).
//   index_bits is written through cfg_we / cfg_wdata while the block is idle.
// Timing:
//   a byte is taken into the input register and folded into the residue when it
//   leaves that register; the result of a last item is loaded into the output
//   register in that same step and leaves from there on hash_out. One item per
//   cycle is sustained while no last item is held back by a waiting result; the
//   residue update (constant multiply, 256-entry fold table, two compares) is
//   the loop that sets the clock.
// Reset (rst, synchronous): residue cleared, index_bits back to 4, both
//   register stages empty.
// Stall: while a result waits on hash_out, items without last still move on;
//   a last item holds in the input register, and key_in.ready drops once it
//   is full and blocked.
`default_nettype none

module rolling_key_hash (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire rkh_pkg::idx_bits_t  cfg_wdata,
  rkh_in_if.sink                   key_in,
  rkh_out_if.source                hash_out
);

  // input register
  logic               s1_valid;
  rkh_pkg::key_byte_t s1_byte;
  logic               s1_byte_valid;
  logic               s1_last;
  logic               s1_fire;

  rkh_pkg::hash_t     residue;
  rkh_pkg::hash_t     residue_upd;
  rkh_pkg::idx_bits_t index_bits;

  rkh_pkg::hash_t     mix_hash;
  rkh_pkg::hash_t     mix_bucket;

  // result register
  logic               out_valid;
  rkh_pkg::hash_t     out_hash;
  rkh_pkg::hash_t     out_bucket;

  assign s1_fire = s1_valid && (!s1_last || !out_valid || hash_out.ready);
  assign key_in.ready = !s1_valid || s1_fire;

  assign hash_out.valid        = out_valid;
  assign hash_out.key_hash     = out_hash;
  assign hash_out.bucket_index = out_bucket;

  rkh_fold u_fold (
    .residue      (residue),
    .key_byte     (s1_byte),
    .byte_valid   (s1_byte_valid),
    .residue_next (residue_upd)
  );

  rkh_mix u_mix (
    .residue      (residue_upd),
    .index_bits   (index_bits),
    .key_hash     (mix_hash),
    .bucket_index (mix_bucket)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= rkh_pkg::IdxReset;
    end else if (cfg_we) begin
      index_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.ready) begin
      s1_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.ready && key_in.valid) begin
      s1_byte       <= key_in.key_byte;
      s1_byte_valid <= key_in.byte_valid;
      s1_last       <= key_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue <= '0;
    end else if (s1_fire) begin
      residue <= s1_last ? '0 : residue_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (hash_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_hash   <= mix_hash;
      out_bucket <= mix_bucket;
    end
  end

  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    residue < rkh_pkg::HashMod)
    else $error("residue not reduced below modulus");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (residue == '0))
    else $error("residue not cleared after last item");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> out_valid)
    else $error("last item left no result");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> key_in.ready)
    else $error("empty input register refuses a byte");

  a_blocked_last_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && !hash_out.ready) |=> s1_valid)
    else $error("blocked last item dropped");

endmodule

`default_nettype wire

// ===== rtl/rkh_fold.sv =====
// rolling key hash: one Horner step, residue * 263 + signed byte mod p
// depends on rkh_pkg (fold table and modulus)
`default_nettype none

module rkh_fold (
  input  wire rkh_pkg::hash_t     residue,
  input  wire rkh_pkg::key_byte_t key_byte,
  input  wire logic               byte_valid,
  output rkh_pkg::hash_t          residue_next
);

  logic [rkh_pkg::SumWidth-1:0]  addend;
  logic [rkh_pkg::ProdWidth-1:0] prod;
  rkh_pkg::hash_t                fold;
  logic [rkh_pkg::SumWidth-1:0]  sum;
  logic [rkh_pkg::SumWidth-1:0]  reduced;

  always_comb begin
    // negative byte b - 256 taken as p + b - 256
    if (key_byte[rkh_pkg::ByteWidth-1]) begin
      addend = 31'(rkh_pkg::HashMod) - 31'd256 + 31'(key_byte);
    end else begin
      addend = 31'(key_byte);
    end
    prod = 38'(residue) * 38'(rkh_pkg::HashBase) + 38'(addend);
    fold = rkh_pkg::FoldTable[prod[rkh_pkg::ProdWidth-1:rkh_pkg::HashWidth]];
    // low part plus folded top part stays below 3p
    sum  = 31'(prod[rkh_pkg::HashWidth-1:0]) + 31'(fold);
    if (sum >= rkh_pkg::HashMod2) begin
      reduced = sum - rkh_pkg::HashMod2;
    end else if (sum >= 31'(rkh_pkg::HashMod)) begin
      reduced = sum - 31'(rkh_pkg::HashMod);
    end else begin
      reduced = sum;
    end
    residue_next = byte_valid ? reduced[rkh_pkg::HashWidth-1:0] : residue;
  end

endmodule

`default_nettype wire

// ===== rtl/rkh_mix.sv =====
// rolling key hash: shift-xor scramble of the final residue and bucket mask
// depends on rkh_pkg
`default_nettype none

module rkh_mix (
  input  wire rkh_pkg::hash_t    residue,
  input  wire rkh_pkg::idx_bits_t index_bits,
  output rkh_pkg::hash_t         key_hash,
  output rkh_pkg::hash_t         bucket_index
);

  rkh_pkg::hash_t g;
  rkh_pkg::hash_t mask;

  always_comb begin
    g = residue ^ (residue >> rkh_pkg::MixShiftA) ^ (residue >> rkh_pkg::MixShiftB);
    key_hash = g ^ (g >> rkh_pkg::MixShiftC) ^ (g >> rkh_pkg::MixShiftD);
    if (index_bits >= rkh_pkg::IdxFull) begin
      mask = '1;
    end else begin
      mask = (30'd1 << index_bits) - 30'd1;
    end
    bucket_index = key_hash & mask;
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// rolling key hash testbench: directed keys, bucket width extremes and random
// key traffic with and without sender and receiver idling, checked against a local hash model
// depends on rkh_pkg, rkh_in_if, rkh_out_if and rolling_key_hash
`timescale 1ns / 1ps

module tb_top;

  localparam logic [63:0] KeyPrime     = 64'd1000000009;
  localparam logic [63:0] KeyBase      = 64'd263;
  localparam int          SettleCycles = 4;
  localparam int          RandomItems  = 620;

  typedef struct {
    rkh_pkg::hash_t key_hash;
    rkh_pkg::hash_t bucket_index;
  } hash_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  rkh_pkg::idx_bits_t cfg_wdata;

  rkh_in_if  key_in ();
  rkh_out_if hash_out ();

  rolling_key_hash dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .key_in   (key_in),
    .hash_out (hash_out)
  );

  // hash model state
  rkh_pkg::hash_t     run_residue;
  rkh_pkg::idx_bits_t cur_index_bits;
  hash_result_t       expected_hashes[$];

  int mismatches;
  int hashes_checked;
  int bytes_folded;
  int ignored_items;
  int index_writes;
  int src_idle_pct;
  int snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic rkh_pkg::hash_t fold_key_byte(rkh_pkg::hash_t acc,
                                                   rkh_pkg::key_byte_t b);
    logic [63:0] t;
    t = 64'(acc) * KeyBase;
    // negative byte: add p - |b| so the sum stays nonnegative
    if (b[7]) begin
      t += KeyPrime - (64'd256 - 64'(b));
    end else begin
      t += 64'(b);
    end
    return rkh_pkg::hash_t'(t % KeyPrime);
  endfunction

  function automatic rkh_pkg::hash_t scramble_hash(rkh_pkg::hash_t h);
    rkh_pkg::hash_t g;
    g = h ^ (h >> 20) ^ (h >> 12);
    return g ^ (g >> 7) ^ (g >> 4);
  endfunction

  function automatic rkh_pkg::hash_t index_mask(rkh_pkg::idx_bits_t bits);
    if (bits >= 5'd30) begin
      return '1;
    end
    return rkh_pkg::hash_t'((64'd1 << bits) - 64'd1);
  endfunction

  // output check first, then fold the accepted byte, so one edge never races itself
  always @(posedge clk) begin
    hash_result_t exp_r;
    if (!rst && hash_out.valid && hash_out.ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t unexpected result: key_hash %h bucket_index %h", $time,
                 hash_out.key_hash, hash_out.bucket_index);
        mismatches++;
      end else begin
        exp_r = expected_hashes.pop_front();
        hashes_checked++;
        if (hash_out.key_hash !== exp_r.key_hash) begin
          $display("%0t key_hash mismatch: expected %h actual %h", $time,
                   exp_r.key_hash, hash_out.key_hash);
          mismatches++;
        end
        if (hash_out.bucket_index !== exp_r.bucket_index) begin
          $display("%0t bucket_index mismatch: expected %h actual %h", $time,
                   exp_r.bucket_index, hash_out.bucket_index);
          mismatches++;
        end
      end
    end
    if (!rst && key_in.valid && key_in.ready) begin
      if (key_in.byte_valid) begin
        run_residue = fold_key_byte(run_residue, key_in.key_byte);
        bytes_folded++;
      end
      if (key_in.last) begin
        exp_r.key_hash     = scramble_hash(run_residue);
        exp_r.bucket_index = exp_r.key_hash & index_mask(cur_index_bits);
        expected_hashes.push_back(exp_r);
        run_residue = '0;
      end
    end
  end

  // receiver stalls at random, decided at each falling edge
  always @(negedge clk) begin
    hash_out.ready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_key_item(input rkh_pkg::key_byte_t b, input logic bv,
                               input logic lst);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      key_in.valid      <= 1'b0;
      key_in.key_byte   <= rkh_pkg::key_byte_t'($urandom);
      key_in.byte_valid <= 1'($urandom);
      key_in.last       <= 1'($urandom);
      @(negedge clk);
    end
    key_in.valid      <= 1'b1;
    key_in.key_byte   <= b;
    key_in.byte_valid <= bv;
    key_in.last       <= lst;
    do @(posedge clk); while (!key_in.ready);
    @(negedge clk);
  endtask

  task automatic wait_hashes_done();
    key_in.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(negedge clk);
    // bytes without last may still be folding into the residue
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_index_bits(input rkh_pkg::idx_bits_t bits);
    wait_hashes_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= bits;
    @(negedge clk);
    cfg_we         <= 1'b0;
    cur_index_bits = bits;
    index_writes++;
  endtask

  task automatic send_random_key(inout int counted);
    int r;
    int len;
    logic bv;
    r = $urandom_range(99);
    if (r < 5) begin
      len = 0;
    end else if (r < 85) begin
      len = $urandom_range(1, 10);
    end else if (r < 97) begin
      len = $urandom_range(11, 40);
    end else begin
      len = $urandom_range(41, 120);
    end
    if (len == 0) begin
      send_key_item(rkh_pkg::key_byte_t'($urandom), 1'b0, 1'b1);
      counted++;
    end
    for (int i = 0; i < len; i++) begin
      bv = ($urandom_range(99) >= 8);
      send_key_item(rkh_pkg::key_byte_t'($urandom), bv, i == len - 1);
      counted++;
    end
  endtask

  task automatic test_key_edges();
    // empty key, then single bytes at the signed extremes
    send_key_item(8'h00, 1'b0, 1'b1);
    send_key_item(8'h00, 1'b1, 1'b1);
    send_key_item(8'h7f, 1'b1, 1'b1);
    send_key_item(8'h80, 1'b1, 1'b1);
    send_key_item(8'hff, 1'b1, 1'b1);
    // skipped byte inside a key
    send_key_item(8'h41, 1'b1, 1'b0);
    send_key_item(8'h99, 1'b0, 1'b0);
    send_key_item(8'h42, 1'b1, 1'b1);
    // key closed by a skipped byte keeps the residue as it stands
    send_key_item(8'h10, 1'b1, 1'b0);
    send_key_item(8'haa, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_key_item(8'h7f, 1'b1, i == 4);
    end
  endtask

  task automatic test_index_width();
    write_index_bits(5'd0);
    send_key_item(8'hff, 1'b1, 1'b0);
    send_key_item(8'h7f, 1'b1, 1'b1);
    write_index_bits(5'd30);
    send_key_item(8'h80, 1'b1, 1'b0);
    send_key_item(8'h55, 1'b1, 1'b0);
    send_key_item(8'haa, 1'b1, 1'b1);
    write_index_bits(5'd1);
    send_key_item(8'hc3, 1'b1, 1'b0);
    send_key_item(8'h3c, 1'b1, 1'b1);
    write_index_bits(5'd17);
    send_key_item(8'h5a, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(input int total, input int src_pct, input int snk_pct,
                                     input rkh_pkg::idx_bits_t first_bits);
    int counted;
    int mark;
    write_index_bits(first_bits);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    counted = 0;
    mark    = 0;
    while (counted < total) begin
      if ($urandom_range(9) == 0) begin
        send_key_item(rkh_pkg::key_byte_t'($urandom), 1'b0, 1'b0);
        ignored_items++;
        counted++;
      end
      send_random_key(counted);
      // pause until every hash is out, then pick a random bucket width
      if (counted - mark >= 200) begin
        write_index_bits(rkh_pkg::idx_bits_t'($urandom_range(0, 30)));
        mark = counted;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    key_in.valid      = 1'b0;
    key_in.key_byte   = '0;
    key_in.byte_valid = 1'b0;
    key_in.last       = 1'b0;
    hash_out.ready    = 1'b0;
    run_residue       = '0;
    cur_index_bits    = 5'd4;
    mismatches        = 0;
    hashes_checked    = 0;
    bytes_folded      = 0;
    ignored_items     = 0;
    index_writes      = 0;
    src_idle_pct      = 0;
    snk_idle_pct      = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_key_edges();
    test_index_width();
    test_random_traffic(RandomItems, 36, 62, 5'd30);
    test_random_traffic(RandomItems, 62, 36, 5'd0);
    test_random_traffic(RandomItems, 0, 0, 5'd9);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    wait_hashes_done();
    repeat (8) @(negedge clk);

    $display("checked %0d key hashes over %0d folded bytes, %0d ignored items",
             hashes_checked, bytes_folded, ignored_items);
    $display("%0d bucket width writes, idling on each side and on neither", index_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
